// ===== hdl/bouncing_particle_integrator_assert.svh =====
// Assertion macros for the bouncing particle integrator.
// Define NO_ASSERTIONS to compile them away.
`ifndef BOUNCING_PARTICLE_INTEGRATOR_ASSERT_SVH
`define BOUNCING_PARTICLE_INTEGRATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle
`define BPI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpi: assertion failed");
// Antecedent implies consequent in the next cycle
`define BPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpi: assertion failed");
`else
`define BPI_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BPI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/bpi_pkg.sv =====
// Shared types, constants and helpers for the bouncing particle integrator.
// No dependencies.
`timescale 1ns / 1ps
package bpi_pkg;

  // Particle table
  localparam int PARTICLE_W = 4;
  localparam int PARTICLES  = 1 << PARTICLE_W;

  // Arithmetic widths
  localparam int WIDE_W = 44;
  localparam int PROD_W = 58;

  localparam logic signed [31:0] ONE_Q24     = 32'sd16777216;
  localparam logic signed [31:0] NEG_ONE_Q24 = -32'sd16777216;

  // Register map (word index)
  localparam logic [1:0] REG_FORCE_SCALE  = 2'd0;
  localparam logic [1:0] REG_DECAY_FACTOR = 2'd1;
  localparam logic [1:0] REG_BOUNCE       = 2'd2;

  localparam logic [23:0] FORCE_SCALE_RST  = 24'd1678;
  localparam logic [15:0] DECAY_FACTOR_RST = 16'd58982;
  localparam logic [15:0] BOUNCE_RST       = 16'd62259;

  typedef enum logic [1:0] {
    OP_FORCE   = 2'd0,
    OP_TICK    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_FADD,
    S_TMULV,
    S_TSUMV,
    S_TMOVE,
    S_TBOUNCE,
    S_WRITE
  } state_t;

  typedef enum logic [1:0] {
    MUL_FORCE,
    MUL_ACC,
    MUL_VEL,
    MUL_BOUNCE
  } mul_sel_t;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_INIT,
    STEP_FORCE_ADD,
    STEP_DAMP_ACC,
    STEP_DAMP_VEL,
    STEP_MOVE,
    STEP_BOUNCE
  } step_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    step_t    step;
    logic     write;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic active;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [23:0] force_scale;
    logic [15:0] decay_factor;
    logic [15:0] bounce_factor;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              operation;
    logic [PARTICLE_W-1:0]   particle;
    logic signed [15:0]      force_x;
    logic signed [15:0]      force_y;
    logic signed [15:0]      start_x;
    logic signed [15:0]      start_y;
  } item_t;

  typedef struct packed {
    logic               is_active;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
  } result_t;

  // Saturate a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [31:0] r;
    if (v[WIDE_W-1:31] == {(WIDE_W-31){v[WIDE_W-1]}}) begin
      r = v[31:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, 31'd0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== hdl/bpi_if.sv =====
// Request and response channel interfaces of the particle integrator.
// Depends on bpi_pkg for the particle index width.
`timescale 1ns / 1ps
interface bpi_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [bpi_pkg::PARTICLE_W-1:0] particle;
  logic signed [15:0]            force_x;
  logic signed [15:0]            force_y;
  logic signed [15:0]            start_x;
  logic signed [15:0]            start_y;

  modport source(output valid, operation, particle, force_x, force_y, start_x, start_y,
                 input ready);
  modport sink(input valid, operation, particle, force_x, force_y, start_x, start_y,
               output ready);
endinterface

interface bpi_rsp_if;
  logic               valid;
  logic               ready;
  logic               is_active;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;

  modport source(output valid, is_active, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y,
                 input ready);
  modport sink(input valid, is_active, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y,
               output ready);
endinterface

// ===== hdl/bpi_cfg.sv =====
// APB register block: force scale, decay factor and bounce factor.
// Depends on bpi_pkg.
`timescale 1ns / 1ps
module bpi_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output bpi_pkg::cfg_t       cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.force_scale   <= bpi_pkg::FORCE_SCALE_RST;
      cfg.decay_factor  <= bpi_pkg::DECAY_FACTOR_RST;
      cfg.bounce_factor <= bpi_pkg::BOUNCE_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        bpi_pkg::REG_FORCE_SCALE:  cfg.force_scale   <= pwdata[23:0];
        bpi_pkg::REG_DECAY_FACTOR: cfg.decay_factor  <= pwdata[15:0];
        bpi_pkg::REG_BOUNCE:       cfg.bounce_factor <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (paddr[3:2])
      bpi_pkg::REG_FORCE_SCALE:  prdata = {8'd0, cfg.force_scale};
      bpi_pkg::REG_DECAY_FACTOR: prdata = {16'd0, cfg.decay_factor};
      bpi_pkg::REG_BOUNCE:       prdata = {16'd0, cfg.bounce_factor};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/bpi_dp.sv =====
// Datapath: particle table, working registers, two multiplier lanes (x, y)
// and the output register. Depends on bpi_pkg.
`timescale 1ns / 1ps
module bpi_dp (
  input  logic              clk,
  input  logic              rst,
  input  bpi_pkg::cfg_t     cfg,
  input  bpi_pkg::item_t    item,
  input  bpi_pkg::cmd_t     cmd,
  output bpi_pkg::sts_t     sts,
  output bpi_pkg::result_t  res,
  output logic              res_valid,
  input  logic              res_ready
);

  // Particle table, one entry per particle, one word per axis
  logic signed [31:0] acc_mem [bpi_pkg::PARTICLES][2];
  logic signed [31:0] vel_mem [bpi_pkg::PARTICLES][2];
  logic signed [31:0] pos_mem [bpi_pkg::PARTICLES][2];
  logic [bpi_pkg::PARTICLES-1:0] active_flags;

  // Item registers
  bpi_pkg::op_t                   item_op;
  logic [bpi_pkg::PARTICLE_W-1:0] item_idx;
  logic signed [15:0]             item_force [2];
  logic signed [15:0]             item_start [2];

  // Working registers
  logic                            active_r;
  logic signed [31:0]              acc_r [2];
  logic signed [31:0]              vel_r [2];
  logic signed [31:0]              pos_r [2];
  logic                            hit [2];
  logic signed [bpi_pkg::PROD_W-1:0] prod [2];

  // Lane logic
  logic signed [32:0]                 mul_a [2];
  logic signed [24:0]                 mul_b [2];
  logic signed [bpi_pkg::PROD_W-1:0]  prod_next [2];
  logic signed [41:0]                 shr16 [2];
  logic signed [42:0]                 shr15 [2];
  logic signed [31:0]                 q_sum [2];

  assign sts.op       = item_op;
  assign sts.active   = active_r;
  assign sts.out_free = !res_valid || res_ready;

  // Multiplier operand select and shifts, per axis
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      case (cmd.mul_sel)
        bpi_pkg::MUL_ACC: begin
          mul_a[k] = 33'(acc_r[k]);
          mul_b[k] = {9'd0, cfg.decay_factor};
        end
        bpi_pkg::MUL_VEL: begin
          mul_a[k] = 33'(vel_r[k]);
          mul_b[k] = {9'd0, cfg.decay_factor};
        end
        bpi_pkg::MUL_BOUNCE: begin
          mul_a[k] = -33'(vel_r[k]);
          mul_b[k] = {9'd0, cfg.bounce_factor};
        end
        default: begin
          mul_a[k] = 33'(item_force[k]);
          mul_b[k] = {1'b0, cfg.force_scale};
        end
      endcase
      prod_next[k] = mul_a[k] * mul_b[k];
      shr16[k]     = prod[k][bpi_pkg::PROD_W-1:16];
      shr15[k]     = prod[k][bpi_pkg::PROD_W-1:15];
      q_sum[k]     = bpi_pkg::sat32(bpi_pkg::WIDE_W'(pos_r[k]) +
                                    bpi_pkg::WIDE_W'(vel_r[k]));
    end
  end

  // Control state: flags, active bit of the item, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active_flags <= '0;
      active_r     <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (cmd.load) begin
        active_r <= (bpi_pkg::op_t'(item.operation) == bpi_pkg::OP_RELEASE) ? 1'b0 :
                    active_flags[item.particle];
      end else if (cmd.step == bpi_pkg::STEP_INIT) begin
        active_r <= 1'b1;
      end
      if (cmd.write) begin
        active_flags[item_idx] <= active_r;
        res_valid              <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Table access, working registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op       <= bpi_pkg::op_t'(item.operation);
      item_idx      <= item.particle;
      item_force[0] <= item.force_x;
      item_force[1] <= item.force_y;
      item_start[0] <= item.start_x;
      item_start[1] <= item.start_y;
      for (int k = 0; k < 2; k++) begin
        acc_r[k] <= acc_mem[item.particle][k];
        vel_r[k] <= vel_mem[item.particle][k];
        pos_r[k] <= pos_mem[item.particle][k];
      end
    end

    if (cmd.mul_en) begin
      for (int k = 0; k < 2; k++) begin
        prod[k] <= prod_next[k];
      end
    end

    for (int k = 0; k < 2; k++) begin
      case (cmd.step)
        bpi_pkg::STEP_INIT: begin
          if (!active_r) begin
            acc_r[k] <= '0;
            vel_r[k] <= '0;
            pos_r[k] <= 32'(item_start[k]) <<< 9;
          end
        end
        bpi_pkg::STEP_FORCE_ADD: begin
          acc_r[k] <= bpi_pkg::sat32(bpi_pkg::WIDE_W'(acc_r[k]) +
                                     bpi_pkg::WIDE_W'(shr15[k]));
        end
        bpi_pkg::STEP_DAMP_ACC: begin
          acc_r[k] <= bpi_pkg::sat32(bpi_pkg::WIDE_W'(shr16[k]));
        end
        bpi_pkg::STEP_DAMP_VEL: begin
          vel_r[k] <= bpi_pkg::sat32(bpi_pkg::WIDE_W'(shr16[k]) +
                                     bpi_pkg::WIDE_W'(acc_r[k]));
        end
        bpi_pkg::STEP_MOVE: begin
          // integrate, then clamp at the walls
          acc_r[k] <= '0;
          if (q_sum[k] < bpi_pkg::NEG_ONE_Q24) begin
            pos_r[k] <= bpi_pkg::NEG_ONE_Q24;
            hit[k]   <= 1'b1;
          end else if (q_sum[k] >= bpi_pkg::ONE_Q24) begin
            pos_r[k] <= bpi_pkg::ONE_Q24;
            hit[k]   <= 1'b1;
          end else begin
            pos_r[k] <= q_sum[k];
            hit[k]   <= 1'b0;
          end
        end
        bpi_pkg::STEP_BOUNCE: begin
          if (hit[k]) begin
            vel_r[k] <= bpi_pkg::sat32(bpi_pkg::WIDE_W'(shr16[k]));
          end
        end
        default: ;
      endcase
    end

    if (cmd.write) begin
      for (int k = 0; k < 2; k++) begin
        acc_mem[item_idx][k] <= acc_r[k];
        vel_mem[item_idx][k] <= vel_r[k];
        pos_mem[item_idx][k] <= pos_r[k];
      end
      res.is_active <= active_r;
      res.pos_x     <= active_r ? pos_r[0] : '0;
      res.pos_y     <= active_r ? pos_r[1] : '0;
      res.vel_x     <= active_r ? vel_r[0] : '0;
      res.vel_y     <= active_r ? vel_r[1] : '0;
      res.acc_x     <= active_r ? acc_r[0] : '0;
      res.acc_y     <= active_r ? acc_r[1] : '0;
    end
  end

endmodule

// ===== hdl/bpi_ctrl.sv =====
// Controller: sequences the datapath through force, tick and release words.
// Depends on bpi_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bouncing_particle_integrator_assert.svh"
module bpi_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bpi_pkg::sts_t  sts,
  output bpi_pkg::cmd_t  cmd
);

  bpi_pkg::state_t state;
  bpi_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpi_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    cmd.load    = 1'b0;
    cmd.mul_en  = 1'b0;
    cmd.mul_sel = bpi_pkg::MUL_FORCE;
    cmd.step    = bpi_pkg::STEP_NONE;
    cmd.write   = 1'b0;
    unique case (state)
      bpi_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = bpi_pkg::S_START;
        end
      end
      bpi_pkg::S_START: begin
        case (sts.op)
          bpi_pkg::OP_FORCE: begin
            cmd.step    = bpi_pkg::STEP_INIT;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bpi_pkg::MUL_FORCE;
            state_next  = bpi_pkg::S_FADD;
          end
          bpi_pkg::OP_TICK: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bpi_pkg::MUL_ACC;
            state_next  = sts.active ? bpi_pkg::S_TMULV : bpi_pkg::S_WRITE;
          end
          default: state_next = bpi_pkg::S_WRITE;
        endcase
      end
      bpi_pkg::S_FADD: begin
        cmd.step   = bpi_pkg::STEP_FORCE_ADD;
        state_next = bpi_pkg::S_WRITE;
      end
      bpi_pkg::S_TMULV: begin
        cmd.step    = bpi_pkg::STEP_DAMP_ACC;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bpi_pkg::MUL_VEL;
        state_next  = bpi_pkg::S_TSUMV;
      end
      bpi_pkg::S_TSUMV: begin
        cmd.step   = bpi_pkg::STEP_DAMP_VEL;
        state_next = bpi_pkg::S_TMOVE;
      end
      bpi_pkg::S_TMOVE: begin
        // bounce product is taken from the new velocity alongside the move
        cmd.step    = bpi_pkg::STEP_MOVE;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bpi_pkg::MUL_BOUNCE;
        state_next  = bpi_pkg::S_TBOUNCE;
      end
      bpi_pkg::S_TBOUNCE: begin
        cmd.step   = bpi_pkg::STEP_BOUNCE;
        state_next = bpi_pkg::S_WRITE;
      end
      bpi_pkg::S_WRITE: begin
        if (sts.out_free) begin
          cmd.write  = 1'b1;
          state_next = bpi_pkg::S_IDLE;
        end
      end
      default: state_next = bpi_pkg::S_IDLE;
    endcase
  end

  // Checks
  `BPI_ASSERT_IMPLY(a_write_room, clk, rst, cmd.write, sts.out_free)
  `BPI_ASSERT_NEXT(a_load_starts, clk, rst, cmd.load, state == bpi_pkg::S_START)
  `BPI_ASSERT_NEXT(a_write_idles, clk, rst, cmd.write, state == bpi_pkg::S_IDLE)
  `BPI_ASSERT_IMPLY(a_fadd_after_start, clk, rst, state == bpi_pkg::S_FADD, $past(state) == bpi_pkg::S_START)

endmodule

// ===== hdl/bouncing_particle_integrator.sv =====
// A word is loaded in IDLE and runs START, then FADD for a force word or TMULV, TSUMV,
// TMOVE and TBOUNCE for a tick on an active particle, on the shared x/y multiplier
// lanes, then WRITE, which waits for output room; other words go from START to WRITE.
// A new word is taken only in IDLE. Synchronous active-high reset clears the active
// flags, the controller and output valid, and loads the register defaults.
// Top level: APB register block, controller and datapath. Depends on bpi_pkg, bpi_if.
`timescale 1ns / 1ps
module bouncing_particle_integrator (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bpi_req_if.sink     req,
  bpi_rsp_if.source   rsp
);

  bpi_pkg::cfg_t    cfg;
  bpi_pkg::cmd_t    cmd;
  bpi_pkg::sts_t    sts;
  bpi_pkg::item_t   item;
  bpi_pkg::result_t res;
  logic             req_ready;
  logic             res_valid;

  // Pack the request word
  assign item.operation = req.operation;
  assign item.particle  = req.particle;
  assign item.force_x   = req.force_x;
  assign item.force_y   = req.force_y;
  assign item.start_x   = req.start_x;
  assign item.start_y   = req.start_y;
  assign req.ready      = req_ready;

  // Unpack the result word
  assign rsp.valid     = res_valid;
  assign rsp.is_active = res.is_active;
  assign rsp.pos_x     = res.pos_x;
  assign rsp.pos_y     = res.pos_y;
  assign rsp.vel_x     = res.vel_x;
  assign rsp.vel_y     = res.vel_y;
  assign rsp.acc_x     = res.acc_x;
  assign rsp.acc_y     = res.acc_y;

  bpi_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpi_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (rsp.ready)
  );

endmodule
